### rtl/core/cht_pkg.sv
// Shared constants, codes and types of the chained hash table.
`default_nettype none
package cht_pkg;
    localparam int MAX_ENTRIES = 256;
    localparam int MAX_BUCKETS = 1024;
    localparam int SLOT_W      = 8;
    localparam int BKT_W       = 10;
    localparam int CNT_W       = 9;
    localparam int BT_W        = 11;
    localparam int EP_W        = 4;
    localparam int KEY_W       = 31;

    localparam logic [EP_W-1:0] EP_NONE = '1;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_ERASE = 2'd2;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_ABSENT   = 3'd3;
    localparam logic [2:0] ST_ERASED   = 3'd4;
    localparam logic [2:0] ST_ER_ABS   = 3'd5;
    localparam logic [2:0] ST_NEG_KEY  = 3'd6;
    localparam logic [2:0] ST_FULL     = 3'd7;

    localparam logic [BT_W-1:0] BT_RESET = 11'd8;

    typedef struct packed {
        logic [BT_W-1:0]  buckets_now;
        logic [CNT_W-1:0] size_now;
        logic [CNT_W-1:0] moved;
        logic [BT_W-1:0]  old_bucket_count;
        logic             rehashed;
        logic [31:0]      found_value;
        logic [CNT_W-1:0] comparisons;
        logic [BKT_W-1:0] bucket;
        logic [2:0]       status;
    } res_t;

    typedef struct packed {
        logic              has_next;
        logic [SLOT_W-1:0] next;
    } link_t;

    typedef struct packed {
        logic [EP_W-1:0]   ep;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } bword_t;

    function automatic logic [BT_W-1:0] clamp_bt(input logic [BT_W-1:0] v);
        logic [BT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = 11'd1;
        end else if (v > BT_W'(MAX_BUCKETS)) begin
            r = BT_W'(MAX_BUCKETS);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/core/cht_divider.sv
// Bit-serial remainder unit: key modulo bucket count, one bit per cycle.
`default_nettype none
module cht_divider (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [cht_pkg::KEY_W-1:0] dividend,
    input  wire logic [cht_pkg::BT_W-1:0]  divisor,
    output logic                           done,
    output logic [cht_pkg::BKT_W-1:0]      rem
);
    import cht_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [KEY_W-1:0]  q_reg;
    logic [BKT_W-1:0]  r_reg;
    logic [BT_W-1:0]   trial;
    logic [BKT_W-1:0]  r_next;

    always_comb begin
        trial = {r_reg, q_reg[KEY_W-1]};
        if (trial >= divisor) begin
            r_next = BKT_W'(trial - divisor);
        end else begin
            r_next = trial[BKT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(KEY_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
        end else if (busy_reg) begin
            q_reg <= {q_reg[KEY_W-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;
endmodule
`default_nettype wire

### rtl/core/cht_engine.sv
// Table sequencer: bucket store, entry store, free list, chain walk and rehash.
`default_nettype none
module cht_engine (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [cht_pkg::BT_W-1:0] cfg_wr_data,
    input  wire logic                     start,
    input  wire logic [1:0]               kind,
    input  wire logic [31:0]              key,
    input  wire logic [31:0]              value,
    output logic                          idle,
    output cht_pkg::res_t                 res,
    output logic                          res_valid,
    input  wire logic                     res_ready
);
    import cht_pkg::*;

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_HSTART   = 5'd2;
    localparam logic [4:0] S_HASH     = 5'd3;
    localparam logic [4:0] S_HEADRD   = 5'd4;
    localparam logic [4:0] S_HEADCHK  = 5'd5;
    localparam logic [4:0] S_ENT_RD   = 5'd6;
    localparam logic [4:0] S_ENT_CHK  = 5'd7;
    localparam logic [4:0] S_DECIDE   = 5'd8;
    localparam logic [4:0] S_POP      = 5'd9;
    localparam logic [4:0] S_POP2     = 5'd10;
    localparam logic [4:0] S_APPEND   = 5'd11;
    localparam logic [4:0] S_RH_B     = 5'd12;
    localparam logic [4:0] S_RH_BCHK  = 5'd13;
    localparam logic [4:0] S_RH_E     = 5'd14;
    localparam logic [4:0] S_RH_ECHK  = 5'd15;
    localparam logic [4:0] S_RH_SWAP  = 5'd16;
    localparam logic [4:0] S_R2_RD    = 5'd17;
    localparam logic [4:0] S_R2_ORD   = 5'd18;
    localparam logic [4:0] S_R2_KRD   = 5'd19;
    localparam logic [4:0] S_R2_KEY   = 5'd20;
    localparam logic [4:0] S_R2_DIV   = 5'd21;
    localparam logic [4:0] S_R2_HB    = 5'd22;
    localparam logic [4:0] S_R2_APP   = 5'd23;
    localparam logic [4:0] S_DONE     = 5'd24;

    logic [KEY_W-1:0]  key_mem  [MAX_ENTRIES];
    logic [31:0]       val_mem  [MAX_ENTRIES];
    link_t             link_mem [MAX_ENTRIES];
    bword_t            bkt_mem  [MAX_BUCKETS];
    logic [SLOT_W-1:0] free_mem [MAX_ENTRIES];
    logic [SLOT_W-1:0] ord_mem  [MAX_ENTRIES];

    logic [4:0]        state_reg, state_next;
    logic [BT_W-1:0]   bt_reg, bt_next;
    logic [CNT_W-1:0]  ec_reg, ec_next;
    logic [EP_W-1:0]   epoch_reg, epoch_next;
    logic [CNT_W-1:0]  minfc_reg, minfc_next;
    logic [BKT_W-1:0]  clr_reg, clr_next;
    logic [1:0]        kind_reg, kind_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [31:0]       val_reg, val_next;
    logic [BKT_W-1:0]  bucket_reg, bucket_next;
    logic [CNT_W-1:0]  cmp_reg, cmp_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] prev_reg, prev_next;
    logic              hasprev_reg, hasprev_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [BKT_W-1:0]  ob_reg, ob_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [2:0]        status_reg, status_next;
    logic [31:0]       fval_reg, fval_next;
    logic              rh_reg, rh_next;
    logic [BT_W-1:0]   oldbt_reg, oldbt_next;
    logic [CNT_W-1:0]  moved_reg, moved_next;

    logic [KEY_W-1:0]  key_rd;
    logic [31:0]       val_rd;
    link_t             link_rd;
    bword_t            bw_rd;
    logic [SLOT_W-1:0] free_rd;
    logic [SLOT_W-1:0] ord_rd;

    logic [SLOT_W-1:0] ent_addr;
    logic [BKT_W-1:0]  bkt_addr;
    logic [SLOT_W-1:0] pop_idx;
    logic [SLOT_W-1:0] push_idx;
    logic [SLOT_W-1:0] slot_new;
    logic              used;
    logic              last_ob;

    logic              key_we, val_we, link_we, bkt_we, free_we, ord_we;
    logic [SLOT_W-1:0] key_wa, val_wa, link_wa, free_wa, ord_wa;
    logic [BKT_W-1:0]  bkt_wa;
    logic [31:0]       val_wd;
    link_t             link_wd;
    bword_t            bkt_wd;
    logic [SLOT_W-1:0] free_wd, ord_wd;

    logic              div_start, div_done;
    logic [KEY_W-1:0]  div_dividend;
    logic [BKT_W-1:0]  div_rem;

    assign div_start    = (state_reg == S_HSTART) || (state_reg == S_R2_KEY);
    assign div_dividend = (state_reg == S_R2_KEY) ? key_rd : key_reg;

    cht_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (bt_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign ent_addr = (state_reg == S_R2_KRD || state_reg == S_R2_KEY) ? slot_reg : cur_reg;
    assign bkt_addr = (state_reg == S_RH_B || state_reg == S_RH_BCHK
                       || state_reg == S_RH_E || state_reg == S_RH_ECHK) ? ob_reg : bucket_reg;
    assign pop_idx  = ~ec_reg[SLOT_W-1:0];
    assign push_idx = SLOT_W'(CNT_W'(MAX_ENTRIES) - ec_reg);
    assign slot_new = ({1'b0, pop_idx} < minfc_reg) ? pop_idx : free_rd;
    assign used     = (bw_rd.ep == epoch_reg);
    assign last_ob  = ({1'b0, ob_reg} + BT_W'(1)) == bt_reg;

    always_comb begin
        state_next   = state_reg;
        bt_next      = bt_reg;
        ec_next      = ec_reg;
        epoch_next   = epoch_reg;
        minfc_next   = minfc_reg;
        clr_next     = clr_reg;
        kind_next    = kind_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        bucket_next  = bucket_reg;
        cmp_next     = cmp_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        hasprev_next = hasprev_reg;
        found_next   = found_reg;
        slot_next    = slot_reg;
        ob_next      = ob_reg;
        n_next       = n_reg;
        status_next  = status_reg;
        fval_next    = fval_reg;
        rh_next      = rh_reg;
        oldbt_next   = oldbt_reg;
        moved_next   = moved_reg;

        key_we  = 1'b0;  key_wa  = slot_new;
        val_we  = 1'b0;  val_wa  = slot_new;  val_wd = val_reg;
        link_we = 1'b0;  link_wa = slot_new;  link_wd = '0;
        bkt_we  = 1'b0;  bkt_wa  = bucket_reg; bkt_wd = '0;
        free_we = 1'b0;  free_wa = push_idx;  free_wd = cur_reg;
        ord_we  = 1'b0;  ord_wa  = n_reg[SLOT_W-1:0]; ord_wd = cur_reg;

        unique case (state_reg)
            S_CLEAR: begin
                bkt_we = 1'b1;
                bkt_wa = clr_reg;
                bkt_wd = '{ep: EP_NONE, head: '0, tail: '0};
                clr_next = clr_reg + BKT_W'(1);
                if (clr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    kind_next   = kind;
                    key_next    = key[KEY_W-1:0];
                    val_next    = value;
                    bucket_next = '0;
                    cmp_next    = '0;
                    fval_next   = '0;
                    rh_next     = 1'b0;
                    oldbt_next  = '0;
                    moved_next  = '0;
                    if (key[31]) begin
                        status_next = ST_NEG_KEY;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_HSTART;
                    end
                end
            end
            S_HSTART: state_next = S_HASH;
            S_HASH: begin
                if (div_done) begin
                    bucket_next = div_rem;
                    state_next  = S_HEADRD;
                end
            end
            S_HEADRD: state_next = S_HEADCHK;
            S_HEADCHK: begin
                cmp_next     = '0;
                hasprev_next = 1'b0;
                found_next   = 1'b0;
                if (used) begin
                    cur_next   = bw_rd.head;
                    state_next = S_ENT_RD;
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_ENT_RD: state_next = S_ENT_CHK;
            S_ENT_CHK: begin
                cmp_next = cmp_reg + CNT_W'(1);
                if (key_rd == key_reg) begin
                    found_next = 1'b1;
                    state_next = S_DECIDE;
                end else if (!link_rd.has_next) begin
                    state_next = S_DECIDE;
                end else begin
                    prev_next    = cur_reg;
                    hasprev_next = 1'b1;
                    cur_next     = link_rd.next;
                    state_next   = S_ENT_RD;
                end
            end
            S_DECIDE: begin
                state_next = S_DONE;
                if (kind_reg == KIND_PUT) begin
                    if (found_reg) begin
                        val_we      = 1'b1;
                        val_wa      = cur_reg;
                        status_next = ST_UPDATED;
                    end else if (ec_reg == CNT_W'(MAX_ENTRIES)) begin
                        status_next = ST_FULL;
                    end else if ((BT_W'(ec_reg) + BT_W'(1)) > bt_reg
                                 && bt_reg <= BT_W'(MAX_BUCKETS / 2)) begin
                        rh_next    = 1'b1;
                        oldbt_next = bt_reg;
                        moved_next = ec_reg;
                        ob_next    = '0;
                        n_next     = '0;
                        state_next = S_RH_B;
                    end else begin
                        state_next = S_POP;
                    end
                end else if (kind_reg == KIND_ERASE) begin
                    if (found_reg) begin
                        link_wa = prev_reg;
                        if (link_rd.has_next) begin
                            if (hasprev_reg) begin
                                link_we = 1'b1;
                                link_wd = '{has_next: 1'b1, next: link_rd.next};
                            end else begin
                                bkt_we = 1'b1;
                                bkt_wd = '{ep: bw_rd.ep, head: link_rd.next, tail: bw_rd.tail};
                            end
                        end else if (hasprev_reg) begin
                            link_we = 1'b1;
                            link_wd = '{has_next: 1'b0, next: '0};
                            bkt_we  = 1'b1;
                            bkt_wd  = '{ep: bw_rd.ep, head: bw_rd.head, tail: prev_reg};
                        end else begin
                            bkt_we = 1'b1;
                            bkt_wd = '{ep: EP_NONE, head: '0, tail: '0};
                        end
                        free_we     = 1'b1;
                        ec_next     = ec_reg - CNT_W'(1);
                        status_next = ST_ERASED;
                    end else begin
                        status_next = ST_ER_ABS;
                    end
                end else begin
                    if (found_reg) begin
                        fval_next   = val_rd;
                        status_next = ST_FOUND;
                    end else begin
                        status_next = ST_ABSENT;
                    end
                end
            end
            S_POP: state_next = S_POP2;
            S_POP2: begin
                key_we  = 1'b1;
                val_we  = 1'b1;
                link_we = 1'b1;
                link_wd = '{has_next: 1'b0, next: '0};
                slot_next = slot_new;
                if ({1'b0, pop_idx} < minfc_reg) begin
                    minfc_next = {1'b0, pop_idx};
                end
                state_next = S_APPEND;
            end
            S_APPEND, S_R2_APP: begin
                bkt_we = 1'b1;
                if (used) begin
                    link_we = 1'b1;
                    link_wa = bw_rd.tail;
                    link_wd = '{has_next: 1'b1, next: slot_reg};
                    bkt_wd  = '{ep: bw_rd.ep, head: bw_rd.head, tail: slot_reg};
                end else begin
                    bkt_wd  = '{ep: epoch_reg, head: slot_reg, tail: slot_reg};
                end
                if (state_reg == S_APPEND) begin
                    ec_next     = ec_reg + CNT_W'(1);
                    status_next = ST_INSERTED;
                    state_next  = S_DONE;
                end else begin
                    n_next = n_reg + CNT_W'(1);
                    if ((n_reg + CNT_W'(1)) == ec_reg) begin
                        state_next = S_HSTART;
                    end else begin
                        state_next = S_R2_RD;
                    end
                end
            end
            S_RH_B: state_next = S_RH_BCHK;
            S_RH_BCHK, S_RH_ECHK: begin
                if (state_reg == S_RH_ECHK) begin
                    ord_we = 1'b1;
                    n_next = n_reg + CNT_W'(1);
                end
                if (state_reg == S_RH_BCHK && used) begin
                    cur_next   = bw_rd.head;
                    state_next = S_RH_E;
                end else if (state_reg == S_RH_ECHK && link_rd.has_next) begin
                    cur_next   = link_rd.next;
                    state_next = S_RH_E;
                end else if (last_ob) begin
                    state_next = S_RH_SWAP;
                end else begin
                    ob_next    = ob_reg + BKT_W'(1);
                    state_next = S_RH_B;
                end
            end
            S_RH_E: state_next = S_RH_ECHK;
            S_RH_SWAP: begin
                epoch_next = epoch_reg + EP_W'(1);
                bt_next    = {bt_reg[BT_W-2:0], 1'b0};
                n_next     = '0;
                state_next = S_R2_RD;
            end
            S_R2_RD: state_next = S_R2_ORD;
            S_R2_ORD: begin
                slot_next  = ord_rd;
                state_next = S_R2_KRD;
            end
            S_R2_KRD: state_next = S_R2_KEY;
            S_R2_KEY: state_next = S_R2_DIV;
            S_R2_DIV: begin
                if (div_done) begin
                    bucket_next = div_rem;
                    state_next  = S_R2_HB;
                end
            end
            S_R2_HB: begin
                link_we    = 1'b1;
                link_wa    = slot_reg;
                link_wd    = '{has_next: 1'b0, next: '0};
                state_next = S_R2_APP;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_wr_en) begin
            state_next = S_CLEAR;
            clr_next   = '0;
            bt_next    = clamp_bt(cfg_wr_data);
            ec_next    = '0;
            epoch_next = '0;
            minfc_next = CNT_W'(MAX_ENTRIES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            bt_reg    <= BT_RESET;
            ec_reg    <= '0;
            epoch_reg <= '0;
            minfc_reg <= CNT_W'(MAX_ENTRIES);
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            bt_reg    <= bt_next;
            ec_reg    <= ec_next;
            epoch_reg <= epoch_next;
            minfc_reg <= minfc_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        bucket_reg  <= bucket_next;
        cmp_reg     <= cmp_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        hasprev_reg <= hasprev_next;
        found_reg   <= found_next;
        slot_reg    <= slot_next;
        ob_reg      <= ob_next;
        n_reg       <= n_next;
        status_reg  <= status_next;
        fval_reg    <= fval_next;
        rh_reg      <= rh_next;
        oldbt_reg   <= oldbt_next;
        moved_reg   <= moved_next;
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_wa] <= key_reg;
        end
        if (val_we) begin
            val_mem[val_wa] <= val_wd;
        end
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (bkt_we) begin
            bkt_mem[bkt_wa] <= bkt_wd;
        end
        if (free_we) begin
            free_mem[free_wa] <= free_wd;
        end
        if (ord_we) begin
            ord_mem[ord_wa] <= ord_wd;
        end
        key_rd  <= key_mem[ent_addr];
        val_rd  <= val_mem[ent_addr];
        link_rd <= link_mem[ent_addr];
        bw_rd   <= bkt_mem[bkt_addr];
        free_rd <= free_mem[pop_idx];
        ord_rd  <= ord_mem[n_reg[SLOT_W-1:0]];
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res = '{buckets_now: bt_reg, size_now: ec_reg, moved: moved_reg,
                   old_bucket_count: oldbt_reg, rehashed: rh_reg, found_value: fval_reg,
                   comparisons: cmp_reg, bucket: bucket_reg, status: status_reg};
endmodule
`default_nettype wire

### rtl/core/chained_hash_table.sv
// Top level of the chained hash table: stream ports, result register, engine.
//
// Usage: each slave-side transaction carries one put, get or erase; every
// transaction yields exactly one master-side result transaction, in order.
// The block works on one transaction at a time: s_tready is high only while
// the sequencer is idle. A transaction computes the bucket index in the
// bit-serial remainder unit (start, 31 shift steps, done), reads the
// memories, and compares the chain entries one after another. A put that
// doubles the bucket count adds a scan of the old buckets and of their
// entries, and every entry moved passes through the same remainder unit
// again. Negative keys skip the remainder unit and the chain walk.
// After reset, and after every write of cfg_wr_data, a clearing pass sweeps
// the 1024-entry bucket store, one bucket a cycle; no input is taken
// meanwhile. A write empties the table and restarts it with the bucket
// count written, clamped to 1..1024. When m_tready is low, the result holds
// in the output register and the next transaction may still be accepted
// and processed; the sequencer then waits with its result until the
// register frees up.
`default_nettype none
module chained_hash_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key[31:0], value[63:32]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // status[2:0], bucket[12:3], comparisons[21:13],
                                        // found_value[53:22], rehashed[54],
                                        // old_bucket_count[65:55], moved[74:66],
                                        // size_now[83:75], buckets_now[94:84], zero[95]
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data
);
    import cht_pkg::*;

    logic  eng_idle;
    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic  m_valid_reg;
    res_t  m_data_reg;

    assign s_tready  = eng_idle;
    assign res_ready = !m_valid_reg || m_tready;

    cht_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start       (s_tvalid && s_tready),
        .kind        (s_tuser),
        .key         (s_tdata[31:0]),
        .value       (s_tdata[63:32]),
        .idle        (eng_idle),
        .res         (res),
        .res_valid   (res_valid),
        .res_ready   (res_ready)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};
endmodule
`default_nettype wire

### rtl/core/cht_checker.sv
// Port-level checker of the chained hash table and its bind.
`default_nettype none
module cht_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata
);
    import cht_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == ST_NEG_KEY |->
            m_tdata[12:3] == '0 && m_tdata[21:13] == '0 && m_tdata[54] == 1'b0)
        else $error("rejected key reports bucket or walk");

    a_rehash: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[54] |->
            m_tdata[2:0] == ST_INSERTED && m_tdata[94:84] == {m_tdata[64:55], 1'b0})
        else $error("rehash result inconsistent");

    a_norehash: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[54] |-> m_tdata[65:55] == '0 && m_tdata[74:66] == '0)
        else $error("rehash data without rehash");
endmodule

bind chained_hash_table cht_checker u_cht_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench of the chained hash table: directed table plus random traffic.
`default_nettype none
module testbench;
    import cht_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 1200;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [31:0] value;
        logic        chk;
        res_t        res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        cfg_wr_en;
    logic [10:0] cfg_wr_data;

    chained_hash_table DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // shadow table
    logic [30:0]      tbl_key   [MAX_ENTRIES];
    logic [31:0]      tbl_val   [MAX_ENTRIES];
    int               tbl_next  [MAX_ENTRIES];
    int               chain_hd  [MAX_BUCKETS];
    int               chain_tl  [MAX_BUCKETS];
    int               free_list [MAX_ENTRIES];
    int               free_num;
    int               live_count;
    int               bucket_cnt;
    logic [10:0]      start_buckets;

    res_t             expected_q [$];
    int               mismatches = 0;
    int               idle_cycles = 0;
    bit               hold_off;
    int               recent_keys [$];
    stim_row_t        stim_rows [$];

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic table_clear();
        int i;
        for (i = 0; i < MAX_BUCKETS; i++) chain_hd[i] = -1;
        for (i = 0; i < MAX_ENTRIES; i++) free_list[i] = i;
        free_num = MAX_ENTRIES;
        live_count = 0;
        bucket_cnt = start_buckets == 0 ? 1 :
                     (start_buckets > MAX_BUCKETS ? MAX_BUCKETS : int'(start_buckets));
    endtask

    function automatic int chain_search(int b, logic [30:0] k, output int cmp,
                                        output int prev);
        int i;
        cmp = 0;
        prev = -1;
        i = chain_hd[b];
        while (i >= 0) begin
            cmp++;
            if (tbl_key[i] == k) return i;
            prev = i;
            i = tbl_next[i];
        end
        return -1;
    endfunction

    function automatic void chain_append(int b, int slot);
        tbl_next[slot] = -1;
        if (chain_hd[b] >= 0) tbl_next[chain_tl[b]] = slot;
        else chain_hd[b] = slot;
        chain_tl[b] = slot;
    endfunction

    function automatic void table_grow();
        int order [$];
        int b;
        int i;
        for (b = 0; b < bucket_cnt; b++) begin
            i = chain_hd[b];
            while (i >= 0) begin
                order = {order, i};
                i = tbl_next[i];
            end
        end
        for (b = 0; b < MAX_BUCKETS; b++) chain_hd[b] = -1;
        bucket_cnt = bucket_cnt * 2;
        foreach (order[j]) chain_append(int'(tbl_key[order[j]]) % bucket_cnt, order[j]);
    endfunction

    function automatic res_t table_apply(logic [1:0] kind, logic [31:0] key,
                                         logic [31:0] value);
        res_t r;
        int   b;
        int   cmp;
        int   prev;
        int   slot;
        r = '0;
        if (key[31]) begin
            r.status = ST_NEG_KEY;
        end else begin
            b = int'(key[30:0]) % bucket_cnt;
            slot = chain_search(b, key[30:0], cmp, prev);
            if (kind == KIND_PUT) begin
                if (slot >= 0) begin
                    tbl_val[slot] = value;
                    r.status = ST_UPDATED;
                end else if (live_count >= MAX_ENTRIES || free_num == 0) begin
                    r.status = ST_FULL;
                end else begin
                    if (live_count + 1 > bucket_cnt && bucket_cnt * 2 <= MAX_BUCKETS) begin
                        r.rehashed = 1'b1;
                        r.old_bucket_count = BT_W'(bucket_cnt);
                        r.moved = CNT_W'(live_count);
                        table_grow();
                        b = int'(key[30:0]) % bucket_cnt;
                        void'(chain_search(b, key[30:0], cmp, prev));
                    end
                    free_num--;
                    slot = free_list[free_num];
                    tbl_key[slot] = key[30:0];
                    tbl_val[slot] = value;
                    chain_append(b, slot);
                    live_count++;
                    r.status = ST_INSERTED;
                end
            end else if (kind == KIND_ERASE) begin
                if (slot >= 0) begin
                    if (prev >= 0) tbl_next[prev] = tbl_next[slot];
                    else chain_hd[b] = tbl_next[slot];
                    if (tbl_next[slot] < 0 && prev >= 0) chain_tl[b] = prev;
                    free_list[free_num++] = slot;
                    live_count--;
                    r.status = ST_ERASED;
                end else begin
                    r.status = ST_ER_ABS;
                end
            end else begin
                if (slot >= 0) begin
                    r.found_value = tbl_val[slot];
                    r.status = ST_FOUND;
                end else begin
                    r.status = ST_ABSENT;
                end
            end
            r.bucket = BKT_W'(b);
            r.comparisons = CNT_W'(cmp);
        end
        r.size_now = CNT_W'(live_count);
        r.buckets_now = BT_W'(bucket_cnt);
        return r;
    endfunction

    function automatic string fmt_res(res_t r);
        return $sformatf(
            "st=%0d bkt=%0d cmp=%0d fv=%h rh=%0d ob=%0d mv=%0d sz=%0d bt=%0d",
            r.status, r.bucket, r.comparisons, r.found_value, r.rehashed,
            r.old_bucket_count, r.moved, r.size_now, r.buckets_now);
    endfunction

    task automatic send_op(logic [1:0] kind, logic [31:0] key, logic [31:0] value,
                           bit chk, res_t typed);
        int   gap;
        res_t r;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {value, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = table_apply(kind, key, value);
        if (chk && r != typed)
            $display("directed row disagrees with prediction: %h vs %h", typed, r);
        if (chk) r = typed;
        expected_q = {expected_q, r};
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_start_buckets(logic [10:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        start_buckets = v;
        table_clear();
    endtask

    function automatic logic [31:0] pick_key(int span);
        int u;
        u = $urandom_range(0, 9);
        if (u == 0) return $urandom;
        if (u < 3 && recent_keys.size() != 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        return {1'b0, 31'($urandom_range(0, span))};
    endfunction

    task automatic random_phase(int n, int span);
        logic [31:0] k;
        logic [1:0]  kind;
        repeat (n) begin
            k = pick_key(span);
            kind = 2'($urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 3));
            if (!k[31]) recent_keys = {recent_keys, int'(k)};
            if (recent_keys.size() > 64) void'(recent_keys.pop_front());
            send_op(kind, k, $urandom, 1'b0, '0);
        end
    endtask

    function automatic res_t mk(logic [2:0] st, int b, int c, logic [31:0] fv, int sz, int bt);
        res_t r;
        r = '0;
        r.status = st;
        r.bucket = BKT_W'(b);
        r.comparisons = CNT_W'(c);
        r.found_value = fv;
        r.size_now = CNT_W'(sz);
        r.buckets_now = BT_W'(bt);
        return r;
    endfunction

    function automatic void add_row(logic [1:0] kind, logic [31:0] key, logic [31:0] value,
                                    res_t typed);
        stim_row_t row;
        row.kind  = kind;
        row.key   = key;
        row.value = value;
        row.chk   = 1'b1;
        row.res   = typed;
        stim_rows = {stim_rows, row};
    endfunction

    // result checker
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[94:0]);
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got != want || m_tdata[95] !== 1'b0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected %s", fmt_res(want));
                        $display("          got      %s", fmt_res(got));
                    end
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int w;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                w = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0) w = 0;
                if (w != 0) begin
                    m_tready <= 1'b0;
                    repeat (w) @(posedge aclk);
                end
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        int i;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= KIND_PUT;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        hold_off    = 1'b0;
        start_buckets = BT_RESET;
        table_clear();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: table of 8 buckets, empty
        add_row(KIND_GET,   32'd5,        32'd0,        mk(ST_ABSENT, 5, 0, 0, 0, 8));
        add_row(KIND_PUT,   32'd5,        32'h7fffffff, mk(ST_INSERTED, 5, 0, 0, 1, 8));
        add_row(KIND_PUT,   32'd13,       32'h80000000, mk(ST_INSERTED, 5, 1, 0, 2, 8));
        add_row(KIND_GET,   32'd13,       32'd0,
                mk(ST_FOUND, 5, 2, 32'h80000000, 2, 8));
        add_row(KIND_PUT,   32'd5,        32'hffffffff, mk(ST_UPDATED, 5, 1, 0, 2, 8));
        add_row(2'd3,       32'd5,        32'd0,
                mk(ST_FOUND, 5, 1, 32'hffffffff, 2, 8));
        add_row(KIND_PUT,   32'h80000000, 32'd1,        mk(ST_NEG_KEY, 0, 0, 0, 2, 8));
        add_row(KIND_ERASE, 32'hffffffff, 32'd0,        mk(ST_NEG_KEY, 0, 0, 0, 2, 8));
        add_row(KIND_PUT,   32'h7fffffff, 32'h55aa55aa, mk(ST_INSERTED, 7, 0, 0, 3, 8));
        add_row(KIND_ERASE, 32'd21,       32'd0,        mk(ST_ER_ABS, 5, 2, 0, 3, 8));
        add_row(KIND_ERASE, 32'd5,        32'd0,        mk(ST_ERASED, 5, 1, 0, 2, 8));
        add_row(KIND_GET,   32'd0,        32'hdeadbeef, mk(ST_ABSENT, 0, 0, 0, 2, 8));
        foreach (stim_rows[j])
            send_op(stim_rows[j].kind, stim_rows[j].key, stim_rows[j].value,
                    stim_rows[j].chk, stim_rows[j].res);
        for (i = 0; i < 10; i++) send_op(KIND_PUT, 32'(i * 3 + 100), $urandom, 1'b0, '0);
        send_op(KIND_ERASE, 32'd13, 0, 1'b0, '0);

        // one bucket with forced growth, then the bucket ceiling and a full entry store
        write_start_buckets(11'd0);
        random_phase(60, 200);
        write_start_buckets(11'd1024);
        for (i = 0; i < 258; i++) send_op(KIND_PUT, 32'(i * 1024 + 3), $urandom, 1'b0, '0);
        send_op(KIND_GET, 32'(257 * 1024 + 3), 0, 1'b0, '0);
        write_start_buckets(11'd2047);
        random_phase(40, 5000);

        // long receiver hold-off while requests keep arriving
        write_start_buckets(11'd3);
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_phase(20, 40);
        join
        random_phase(150, 60);
        write_start_buckets(11'd16);
        random_phase(100, 400);
        write_start_buckets(BT_RESET);
        random_phase(100, 30);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
